>>> design/pstc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pstc_pkg;

  // Sequencer states: one multiply or one add/compare step per state.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_STEP,
    ST_INTEG,
    ST_MUL_P,
    ST_MUL_I,
    ST_TORQUE,
    ST_SLEW,
    ST_DONE
  } pstc_state_t;

  // Register indexes on the configuration port (byte address is 4 times this).
  localparam logic [2:0] REG_TIME_STEP  = 3'd0;
  localparam logic [2:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [2:0] REG_INTEG_GAIN = 3'd2;
  localparam logic [2:0] REG_TORQUE_CAP = 3'd3;
  localparam logic [2:0] REG_INTEG_CAP  = 3'd4;
  localparam logic [2:0] REG_SLEW_STEP  = 3'd5;

  // Register reset values.
  localparam logic [15:0] TIME_STEP_RST  = 16'd655;
  localparam logic [15:0] PROP_GAIN_RST  = 16'd256;
  localparam logic [15:0] INTEG_GAIN_RST = 16'd0;
  localparam logic [14:0] TORQUE_CAP_RST = 15'd32767;
  localparam logic [30:0] INTEG_CAP_RST  = 31'd2560;
  localparam logic [23:0] SLEW_STEP_RST  = 24'd256;

  // Control constants: 5 m/s error window, 5/3.6 m/s low-speed guard (Q8.8),
  // brake duty in stop mode.
  localparam logic signed [16:0] ERR_WINDOW = 17'sd1280;
  localparam logic signed [15:0] LOW_SPEED  = 16'sd356;
  localparam logic [15:0]        BRAKE_ON   = 16'd50000;

endpackage

`default_nettype wire

>>> design/pi_speed_torque_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// PI speed controller producing one torque command and brake duty per tick.
// A tick word carries a measured and a requested speed (signed Q8.8 m/s); a
// request at or below zero is stop mode and returns zero torque with a brake
// duty of 50000 while the integrator and previous torque are held. Otherwise
// the error is integrated (only inside a 5 m/s window, clamped to 0..integ_cap),
// the PI sum is capped at torque_cap, slew-limited against the previous torque,
// zeroed if negative below 5/3.6 m/s, truncated toward zero to whole Nm and
// saturated to 16 bits. All three products run through one 32x17 multiplier
// under a small sequencer. A normal tick steps through MUL_STEP, INTEG, MUL_P,
// MUL_I, TORQUE and SLEW and loads its result in DONE; a stop tick goes from
// IDLE straight to DONE. A new word is taken only while the sequencer is idle,
// and a result still waiting in the output register holds the sequencer in DONE
// before it goes idle again. Because the result sits in an output register, the
// next word can be accepted while the previous result waits. Configuration
// registers sit at byte addresses 0, 4, ... 20 and should be written only while
// idle.
module pi_speed_torque_controller
  import pstc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_measured_speed,
  input  wire logic signed [15:0] in_requested_speed,
  // Result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_torque_cmd,
  output logic [15:0]             out_brake_duty,
  // Configuration port
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [4:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  pstc_state_t state_r, state_nxt;

  // Configuration registers
  logic [15:0] time_step_r, prop_gain_r, integ_gain_r;
  logic [14:0] torque_cap_r;
  logic [30:0] integ_cap_r;
  logic [23:0] slew_step_r;

  // Work registers
  logic signed [16:0] e_r, e_nxt;
  logic signed [15:0] meas_r, meas_nxt;
  logic               stop_r, stop_nxt;
  logic signed [48:0] prod_r, prod_nxt;
  logic signed [33:0] acc_r, acc_nxt;
  logic [30:0]        ie_r, ie_nxt;
  logic signed [39:0] last_r, last_nxt;
  logic signed [39:0] torque_r, torque_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_torque_cmd_r, out_torque_cmd_nxt;
  logic [15:0]        out_brake_duty_r, out_brake_duty_nxt;

  // Shared multiplier
  logic signed [31:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [48:0] mul_p;

  // Datapath intermediates
  logic               accept;
  logic               cfg_wr;
  logic               load_out;
  logic               in_win;
  logic signed [32:0] step_w;
  logic signed [33:0] isum;
  logic signed [49:0] tsum;
  logic signed [41:0] tshift, tcap_lim;
  logic signed [40:0] diff, stp, slew_up, slew_dn;
  logic signed [39:0] tguard, tadj;
  logic signed [31:0] whole;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_torque_cmd = out_torque_cmd_r;
  assign out_brake_duty = out_brake_duty_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign load_out   = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Configuration read-back.
  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_TIME_STEP:  cfg_prdata = {16'd0, time_step_r};
      REG_PROP_GAIN:  cfg_prdata = {16'd0, prop_gain_r};
      REG_INTEG_GAIN: cfg_prdata = {16'd0, integ_gain_r};
      REG_TORQUE_CAP: cfg_prdata = {17'd0, torque_cap_r};
      REG_INTEG_CAP:  cfg_prdata = {1'b0, integ_cap_r};
      REG_SLEW_STEP:  cfg_prdata = {8'd0, slew_step_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_requested_speed <= 16'sd0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MUL_STEP;
          end
        end
      end
      ST_MUL_STEP: state_nxt = ST_INTEG;
      ST_INTEG:    state_nxt = ST_MUL_P;
      ST_MUL_P:    state_nxt = ST_MUL_I;
      ST_MUL_I:    state_nxt = ST_TORQUE;
      ST_TORQUE:   state_nxt = ST_SLEW;
      ST_SLEW:     state_nxt = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    unique case (state_r)
      ST_MUL_STEP: begin
        mul_a = 32'(e_r);
        mul_b = $signed({1'b0, time_step_r});
      end
      ST_MUL_I: begin
        mul_a = $signed({1'b0, ie_r});
        mul_b = $signed({1'b0, integ_gain_r});
      end
      default: begin
        mul_a = 32'(e_r);
        mul_b = $signed({1'b0, prop_gain_r});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Integrator step: floor((e * dt) / 65536), applied only inside the window,
  // then clamped to 0..integ_cap.
  assign step_w = prod_r[48:16];
  assign in_win = (e_r > -ERR_WINDOW) && (e_r < ERR_WINDOW);
  assign isum   = $signed({3'b000, ie_r}) + (in_win ? 34'(step_w) : 34'sd0);

  // PI sum in 1/65536 Nm, floored to 1/256 Nm and capped above.
  assign tsum     = 50'(acc_r) + 50'(prod_r);
  assign tshift   = tsum[49:8];
  assign tcap_lim = $signed({19'd0, torque_cap_r, 8'd0});

  // Slew limit against the previous torque.
  assign diff    = 41'(torque_r) - 41'(last_r);
  assign stp     = $signed({17'd0, slew_step_r});
  assign slew_up = 41'(last_r) + stp;
  assign slew_dn = 41'(last_r) - stp;

  // Low-speed guard, truncation toward zero to whole Nm.
  assign tguard = ((meas_r < LOW_SPEED) && (torque_r < 40'sd0)) ? 40'sd0 : torque_r;
  assign tadj   = (tguard < 40'sd0) ? (tguard + 40'sd255) : tguard;
  assign whole  = tadj[39:8];

  // Register updates per sequencer step.
  always_comb begin
    e_nxt              = e_r;
    meas_nxt           = meas_r;
    stop_nxt           = stop_r;
    prod_nxt           = prod_r;
    acc_nxt            = acc_r;
    ie_nxt             = ie_r;
    last_nxt           = last_r;
    torque_nxt         = torque_r;
    out_torque_cmd_nxt = out_torque_cmd_r;
    out_brake_duty_nxt = out_brake_duty_r;
    out_valid_nxt      = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          e_nxt    = 17'(in_requested_speed) - 17'(in_measured_speed);
          meas_nxt = in_measured_speed;
          stop_nxt = (in_requested_speed <= 16'sd0);
        end
      end
      ST_MUL_STEP: begin
        prod_nxt = mul_p;
      end
      ST_INTEG: begin
        if (isum > $signed({3'b000, integ_cap_r})) begin
          ie_nxt = integ_cap_r;
        end else if (isum < 34'sd0) begin
          ie_nxt = 31'd0;
        end else begin
          ie_nxt = isum[30:0];
        end
      end
      ST_MUL_P: begin
        prod_nxt = mul_p;
      end
      ST_MUL_I: begin
        acc_nxt  = prod_r[33:0];
        prod_nxt = mul_p;
      end
      ST_TORQUE: begin
        torque_nxt = (tshift > tcap_lim) ? tcap_lim[39:0] : tshift[39:0];
      end
      ST_SLEW: begin
        priority if (diff > stp) begin
          torque_nxt = slew_up[39:0];
          last_nxt   = slew_up[39:0];
        end else if (diff < -stp) begin
          torque_nxt = slew_dn[39:0];
          last_nxt   = slew_dn[39:0];
        end else begin
          last_nxt   = torque_r;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          if (stop_r) begin
            out_torque_cmd_nxt = 16'sd0;
            out_brake_duty_nxt = BRAKE_ON;
          end else begin
            out_brake_duty_nxt = 16'd0;
            priority if (whole > 32'sd32767) begin
              out_torque_cmd_nxt = 16'sd32767;
            end else if (whole < -32'sd32768) begin
              out_torque_cmd_nxt = -16'sd32768;
            end else begin
              out_torque_cmd_nxt = whole[15:0];
            end
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      ie_r         <= 31'd0;
      last_r       <= 40'sd0;
      time_step_r  <= TIME_STEP_RST;
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      torque_cap_r <= TORQUE_CAP_RST;
      integ_cap_r  <= INTEG_CAP_RST;
      slew_step_r  <= SLEW_STEP_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ie_r        <= ie_nxt;
      last_r      <= last_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr[4:2])
          REG_TIME_STEP:  time_step_r  <= cfg_pwdata[15:0];
          REG_PROP_GAIN:  prop_gain_r  <= cfg_pwdata[15:0];
          REG_INTEG_GAIN: integ_gain_r <= cfg_pwdata[15:0];
          REG_TORQUE_CAP: torque_cap_r <= cfg_pwdata[14:0];
          REG_INTEG_CAP:  integ_cap_r  <= cfg_pwdata[30:0];
          REG_SLEW_STEP:  slew_step_r  <= cfg_pwdata[23:0];
          default: begin
            time_step_r <= time_step_r;
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    e_r              <= e_nxt;
    meas_r           <= meas_nxt;
    stop_r           <= stop_nxt;
    prod_r           <= prod_nxt;
    acc_r            <= acc_nxt;
    torque_r         <= torque_nxt;
    out_torque_cmd_r <= out_torque_cmd_nxt;
    out_brake_duty_r <= out_brake_duty_nxt;
  end

endmodule

`default_nettype wire

>>> tb/pi_tick_checker.sv
`timescale 1ns / 1ps

// Watches the tick, result and register ports of the PI speed controller.
// It keeps its own copy of the controller state and settings, predicts the
// result of every accepted tick word and compares each result word in order.
module pi_tick_checker
  import pstc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_measured_speed,
  input  logic signed [15:0] in_requested_speed,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_torque_cmd,
  input  logic [15:0]        out_brake_duty,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 errors,
  output int                 pending,
  output int                 checked,
  output int                 stop_ticks,
  output int                 guard_hits,
  output int                 clamp_hits
);

  typedef struct packed {
    logic signed [15:0] torque;
    logic [15:0]        brake;
  } tick_result_t;

  // Settings as last written on the register port.
  logic [15:0] dt_q16;
  logic [15:0] kp_q8;
  logic [15:0] ki_q8;
  logic [14:0] torque_limit;
  logic [30:0] integ_limit;
  logic [23:0] slew_limit;

  // Controller state: integrated error in 1/256 m, last torque in 1/256 Nm.
  longint integ_acc;
  longint prev_torque;

  tick_result_t torque_expect_q[$];
  int n_err, n_checked, n_stop, n_guard, n_clamp;

  initial begin
    n_err = 0;
    n_checked = 0;
    n_stop = 0;
    n_guard = 0;
    n_clamp = 0;
  end

  // One control tick: updates the state and returns the result word.
  function automatic tick_result_t run_pi_tick(input logic signed [15:0] meas,
                                               input logic signed [15:0] req);
    tick_result_t res;
    longint err, mag, trq, step, whole;
    res.torque = '0;
    res.brake = '0;
    if (req <= 0) begin
      // Stop mode leaves the state untouched.
      res.brake = BRAKE_ON;
      n_stop++;
      return res;
    end
    err = longint'(req) - longint'(meas);
    mag = (err < 0) ? -err : err;

    // Integrate only inside the error window, then clamp to the bound.
    if (mag < longint'(ERR_WINDOW))
      integ_acc = integ_acc + ((err * longint'(dt_q16)) >>> 16);
    if (integ_acc > longint'(integ_limit)) begin
      integ_acc = longint'(integ_limit);
      n_clamp++;
    end else if (integ_acc < 0) begin
      integ_acc = 0;
      n_clamp++;
    end

    // PI sum in 1/65536 Nm, floored down to 1/256 Nm, capped above.
    trq = (err * longint'(kp_q8) + integ_acc * longint'(ki_q8)) >>> 8;
    if (trq > longint'(torque_limit) * 256)
      trq = longint'(torque_limit) * 256;

    // Rate limit against the previous torque.
    step = longint'(slew_limit);
    if (trq - prev_torque > step)
      trq = prev_torque + step;
    else if (trq - prev_torque < -step)
      trq = prev_torque - step;
    prev_torque = trq;

    // No regenerative torque at low speed; the stored torque keeps its sign.
    if (meas < LOW_SPEED && trq < 0) begin
      trq = 0;
      n_guard++;
    end

    whole = (trq >= 0) ? (trq >>> 8) : -((-trq) >>> 8);
    if (whole > 32767)
      whole = 32767;
    else if (whole < -32768)
      whole = -32768;
    res.torque = 16'(whole);
    return res;
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      dt_q16 = TIME_STEP_RST;
      kp_q8 = PROP_GAIN_RST;
      ki_q8 = INTEG_GAIN_RST;
      torque_limit = TORQUE_CAP_RST;
      integ_limit = INTEG_CAP_RST;
      slew_limit = SLEW_STEP_RST;
      integ_acc = 0;
      prev_torque = 0;
      torque_expect_q.delete();
    end else begin
      // A result leaving at this edge always belongs to an earlier tick word.
      if (out_valid && out_ready) begin
        if (torque_expect_q.size() == 0) begin
          n_err++;
          $display("%0t: result word torque %0d brake %0d arrived with no tick pending",
                   $time, out_torque_cmd, out_brake_duty);
        end else begin
          want = torque_expect_q.pop_front();
          n_checked++;
          if (out_torque_cmd !== want.torque) begin
            n_err++;
            $display("%0t: torque_cmd expected %0d, got %0d",
                     $time, want.torque, out_torque_cmd);
          end
          if (out_brake_duty !== want.brake) begin
            n_err++;
            $display("%0t: brake_duty expected %0d, got %0d",
                     $time, want.brake, out_brake_duty);
          end
        end
      end

      if (in_valid && in_ready)
        torque_expect_q.push_back(run_pi_tick(in_measured_speed, in_requested_speed));

      // Register writes; values are cut to the register width.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_TIME_STEP:  dt_q16 = cfg_pwdata[15:0];
          REG_PROP_GAIN:  kp_q8 = cfg_pwdata[15:0];
          REG_INTEG_GAIN: ki_q8 = cfg_pwdata[15:0];
          REG_TORQUE_CAP: torque_limit = cfg_pwdata[14:0];
          REG_INTEG_CAP:  integ_limit = cfg_pwdata[30:0];
          REG_SLEW_STEP:  slew_limit = cfg_pwdata[23:0];
          default: ;
        endcase
      end
    end
    pending <= torque_expect_q.size();
    errors <= n_err;
    checked <= n_checked;
    stop_ticks <= n_stop;
    guard_hits <= n_guard;
    clamp_hits <= n_clamp;
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

// Drives tick words and register settings into the PI speed controller and
// gives the verdict from the checker's error and pending counts.
module tb
  import pstc_pkg::*;
();

  localparam int NUM_PHASES = 8;
  localparam int PHASE_WORDS = 205;
  localparam int NUM_DIRECTED = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1_000_000;

  // Addresses past the last register; writes there must change nothing.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_measured_speed = '0;
  logic signed [15:0] in_requested_speed = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_torque_cmd;
  logic [15:0]        out_brake_duty;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [4:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  int errors, pending, checked, stop_ticks, guard_hits, clamp_hits;
  int hold_req = 0;
  bit steady = 1'b0;
  int cycles = 0;

  // Directed ticks: stop requests, field extremes, window and guard edges.
  int dir_meas [0:NUM_DIRECTED-1] = '{0, 0, 100, 0, 0, -32768, 32767, 32767, 1000, 1000,
                                      2280, 2279, 355, 356, -32768, 355, 500, -200,
                                      32767, 12345};
  int dir_req [0:NUM_DIRECTED-1] = '{0, -32768, -1, 1, 32767, 32767, 1, 32767, 2279, 2280,
                                     1000, 1000, 1, 1, 1, 32767, 300, 400, 32767, -12345};

  always #5 clk = ~clk;

  pi_speed_torque_controller u_dut (.*);

  pi_tick_checker u_checker (.*);

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one tick word, hold it until taken, then maybe leave a gap.
  task automatic send_tick(input logic signed [15:0] meas, input logic signed [15:0] req);
    int gap, r;
    in_valid <= 1'b1;
    in_measured_speed <= meas;
    in_requested_speed <= req;
    do @(posedge clk); while (!in_ready);
    gap = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r >= 93)
        gap = $urandom_range(10, 40);
      else if (r >= 60)
        gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // One register write: a setup phase, an access phase that waits for pready, then idle.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // One set of register values per phase: both extremes, a tuned loop, a tight integrator
  // bound, random values in working ranges, and random values with junk in the upper bits.
  task automatic load_settings(input int phase);
    case (phase)
      0: begin
        reg_write(REG_TIME_STEP, 32'hFFFF);
        reg_write(REG_PROP_GAIN, 32'hFFFF);
        reg_write(REG_INTEG_GAIN, 32'hFFFF);
        reg_write(REG_TORQUE_CAP, 32'h7FFF);
        reg_write(REG_INTEG_CAP, 32'h7FFF_FFFF);
        reg_write(REG_SLEW_STEP, 32'hFF_FFFF);
      end
      1: begin
        reg_write(REG_TIME_STEP, 32'd0);
        reg_write(REG_PROP_GAIN, 32'd0);
        reg_write(REG_INTEG_GAIN, 32'd0);
        reg_write(REG_TORQUE_CAP, 32'd0);
        reg_write(REG_INTEG_CAP, 32'd0);
        reg_write(REG_SLEW_STEP, 32'd0);
      end
      2: begin
        reg_write(REG_TIME_STEP, 32'd655);
        reg_write(REG_PROP_GAIN, 32'd2560);
        reg_write(REG_INTEG_GAIN, 32'd1024);
        reg_write(REG_TORQUE_CAP, 32'd300);
        reg_write(REG_INTEG_CAP, 32'd5000);
        reg_write(REG_SLEW_STEP, 32'd5120);
      end
      3: begin
        reg_write(REG_TIME_STEP, 32'hFFFF);
        reg_write(REG_PROP_GAIN, 32'd256);
        reg_write(REG_INTEG_GAIN, 32'hFFFF);
        reg_write(REG_TORQUE_CAP, 32'h7FFF);
        reg_write(REG_INTEG_CAP, 32'd100);
        reg_write(REG_SLEW_STEP, 32'hFF_FFFF);
      end
      6: begin
        reg_write(REG_TIME_STEP, $urandom_range(0, 2000));
        reg_write(REG_PROP_GAIN, $urandom_range(0, 1024));
        reg_write(REG_INTEG_GAIN, $urandom_range(0, 4096));
        reg_write(REG_TORQUE_CAP, $urandom_range(0, 500));
        reg_write(REG_INTEG_CAP, $urandom_range(0, 20000));
        reg_write(REG_SLEW_STEP, $urandom_range(0, 4096));
      end
      default: begin
        reg_write(REG_TIME_STEP, $urandom);
        reg_write(REG_PROP_GAIN, $urandom);
        reg_write(REG_INTEG_GAIN, $urandom);
        reg_write(REG_TORQUE_CAP, $urandom);
        reg_write(REG_INTEG_CAP, $urandom);
        reg_write(REG_SLEW_STEP, $urandom);
        reg_write(REG_SPARE_A, $urandom);
        reg_write(REG_SPARE_B, $urandom);
      end
    endcase
  endtask

  // Result side: short and long random stalls, plus one long hold on request.
  initial begin
    int stall_left, holds_seen, r;
    stall_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_req != holds_seen) begin
        holds_seen = hold_req;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !steady) begin
        r = $urandom_range(0, 99);
        if (r >= 97)
          stall_left = $urandom_range(20, 60);
        else if (r >= 72)
          stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int r, m, q;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_tick(16'(dir_meas[i]), 16'(dir_req[i]));

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      load_settings(p);
      steady = (p % 3 == 1);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // Hold the result side off for a long stretch so the block backs up.
        if (p == 2 && k == 30)
          hold_req <= hold_req + 1;
        r = $urandom_range(0, 99);
        if (r < 12) begin
          q = -$urandom_range(0, 32768);
          m = $urandom_range(0, 65535);
        end else if (r < 60) begin
          // Tracking near the request, mostly inside the integration window.
          q = $urandom_range(1, 32767);
          m = q + $urandom_range(0, 2600) - 1300;
        end else if (r < 75) begin
          // Slow driving around the regenerative guard.
          q = $urandom_range(1, 2000);
          m = $urandom_range(0, 800) - 400;
        end else begin
          q = $urandom;
          m = $urandom;
        end
        send_tick(16'(m), 16'(q));
      end
    end
    drain();

    $display("Checked %0d result words over %0d register settings.", checked, NUM_PHASES + 1);
    $display("Stop ticks %0d, low-speed torque zeroed %0d, integrator clamped %0d.",
             stop_ticks, guard_hits, clamp_hits);
    if (errors == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
